[src/dps_pkg.sv]
// Shared types and constants for the distinct prime split block.
// Used by dps_ctrl, dps_datapath and distinct_prime_split_core.
`default_nettype none

package dps_pkg;

    // Width of the value to factor and of both divisor results
    localparam int VALUE_BITS = 24;
    // Square of the trial divisor runs a little past the reduced value
    localparam int SQ_BITS    = VALUE_BITS + 2;
    // Product of the running prime product and one factor
    localparam int PROD_BITS  = 2 * VALUE_BITS;
    // Divider step counter, one step per quotient bit
    localparam int STEP_BITS  = $clog2(VALUE_BITS);

    typedef logic [VALUE_BITS-1:0] value_t;

    // Datapath operations issued by the controller
    typedef enum logic [2:0] {
        OP_NONE,
        OP_LOAD,
        OP_DIV_START,
        OP_DIV_STEP,
        OP_REDUCE,
        OP_ADVANCE,
        OP_FINAL,
        OP_EMIT
    } dp_op_t;

    typedef struct packed {
        dp_op_t op;
    } dp_cmd_t;

    typedef struct packed {
        logic loop_go;   // trial divisor squared still within reduced value
        logic div_last;  // divider is on its last quotient bit
        logic rem_zero;  // finished division left no remainder
        logic out_free;  // output register can take a new item
    } dp_status_t;

endpackage

`default_nettype wire

[src/distinct_prime_split_core.sv]
// Top level of the distinct prime split block: splits a value with at least two
// distinct primes into its smallest prime and the product of its other primes.
// Depends on dps_pkg, dps_ctrl and dps_datapath.
//
//  channel   handshake              payload
//  req       req_valid/req_ready    value
//  rsp       rsp_valid/rsp_ready    found, first_divisor, second_divisor
//
// One item at a time. Each trial divisor (2, then odd numbers up to the square
// root of the reduced value) takes a full division, and each found prime is
// divided out again until a remainder is left; the one-bit-per-cycle restoring
// divider does this work. A worst-case 24-bit value is a large prime, which
// runs through 2048 trial divisors.
// Reset clears the controller and the output valid; nothing else needs a pass.
// A new item is taken while a result waits in the output register.
`default_nettype none

module distinct_prime_split_core (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           req_valid,
    output logic                                req_ready,
    input  wire logic [dps_pkg::VALUE_BITS-1:0] value,
    output logic                                rsp_valid,
    input  wire logic                           rsp_ready,
    output logic                                found,
    output logic [dps_pkg::VALUE_BITS-1:0]      first_divisor,
    output logic [dps_pkg::VALUE_BITS-1:0]      second_divisor
);
    import dps_pkg::*;

    dp_cmd_t    cmd;
    dp_status_t status;

    dps_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .status    (status),
        .cmd       (cmd)
    );

    dps_datapath u_datapath (
        .clk            (clk),
        .rst_n          (rst_n),
        .cmd            (cmd),
        .status         (status),
        .value          (value),
        .rsp_valid      (rsp_valid),
        .rsp_ready      (rsp_ready),
        .found          (found),
        .first_divisor  (first_divisor),
        .second_divisor (second_divisor)
    );

endmodule

`default_nettype wire

[src/dps_ctrl.sv]
// Controller state machine of the distinct prime split block.
// Depends on dps_pkg; drives dps_datapath through dp_cmd_t and reads dp_status_t.
`default_nettype none

module dps_ctrl (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               req_valid,
    output logic                    req_ready,
    input  wire dps_pkg::dp_status_t status,
    output dps_pkg::dp_cmd_t        cmd
);
    import dps_pkg::*;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CHECK,
        ST_DIV,
        ST_TEST,
        ST_OUT
    } state_t;

    state_t state_reg;
    state_t state_next;

    // Decode the current state into a datapath operation and next state
    always_comb
    begin
        state_next = state_reg;
        cmd.op     = OP_NONE;
        req_ready  = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                req_ready = 1'b1;
                if (req_valid)
                begin
                    cmd.op     = OP_LOAD;
                    state_next = ST_CHECK;
                end
            end
            ST_CHECK:
            begin
                // Try the current divisor while its square fits, else wrap up
                if (status.loop_go)
                begin
                    cmd.op     = OP_DIV_START;
                    state_next = ST_DIV;
                end
                else
                begin
                    cmd.op     = OP_FINAL;
                    state_next = ST_OUT;
                end
            end
            ST_DIV:
            begin
                cmd.op = OP_DIV_STEP;
                if (status.div_last)
                begin
                    state_next = ST_TEST;
                end
            end
            ST_TEST:
            begin
                // Divide out the factor again on a hit, else move on
                if (status.rem_zero)
                begin
                    cmd.op     = OP_REDUCE;
                    state_next = ST_DIV;
                end
                else
                begin
                    cmd.op     = OP_ADVANCE;
                    state_next = ST_CHECK;
                end
            end
            ST_OUT:
            begin
                if (status.out_free)
                begin
                    cmd.op     = OP_EMIT;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Hold state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

`default_nettype wire

[src/dps_datapath.sv]
// Datapath of the distinct prime split block: trial divisor, serial divider,
// prime bookkeeping and output register. Depends on dps_pkg.
`default_nettype none

module dps_datapath (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire dps_pkg::dp_cmd_t   cmd,
    output dps_pkg::dp_status_t     status,
    input  wire logic [dps_pkg::VALUE_BITS-1:0] value,
    output logic                    rsp_valid,
    input  wire logic               rsp_ready,
    output logic                    found,
    output logic [dps_pkg::VALUE_BITS-1:0] first_divisor,
    output logic [dps_pkg::VALUE_BITS-1:0] second_divisor
);
    import dps_pkg::*;

    value_t                 v_reg;      // value with found primes divided out
    value_t                 d_reg;      // trial divisor
    logic [SQ_BITS-1:0]     sq_reg;     // d_reg squared
    value_t                 rem_reg;
    value_t                 quo_reg;
    logic [STEP_BITS-1:0]   step_reg;
    logic                   hit_reg;    // d_reg already recorded as a prime
    logic [1:0]             count_reg;  // distinct primes seen, saturates at two
    value_t                 first_reg;
    value_t                 rest_reg;
    logic                   out_valid_reg;
    logic                   found_reg;
    value_t                 first_out_reg;
    value_t                 second_out_reg;

    logic [VALUE_BITS:0]    rem_sh;
    logic [VALUE_BITS+1:0]  diff;
    logic                   fits;
    value_t                 rem_new;
    value_t                 quo_new;
    value_t                 mul_b;
    logic [PROD_BITS-1:0]   prod;
    logic [1:0]             count_inc;

    // One restoring division step per cycle
    always_comb
    begin
        rem_sh  = {rem_reg, quo_reg[VALUE_BITS-1]};
        diff    = {1'b0, rem_sh} - {2'b00, d_reg};
        fits    = !diff[VALUE_BITS+1];
        rem_new = fits ? diff[VALUE_BITS-1:0] : rem_sh[VALUE_BITS-1:0];
        quo_new = {quo_reg[VALUE_BITS-2:0], fits};
    end

    // Extend the product of the other primes by the new one
    assign mul_b     = (cmd.op == OP_FINAL) ? v_reg : d_reg;
    assign prod      = PROD_BITS'(rest_reg) * PROD_BITS'(mul_b);
    assign count_inc = (count_reg == 2'd2) ? 2'd2 : count_reg + 2'd1;

    assign status.loop_go  = (sq_reg <= SQ_BITS'(v_reg));
    assign status.div_last = (step_reg == STEP_BITS'(VALUE_BITS - 1));
    assign status.rem_zero = (rem_reg == '0);
    assign status.out_free = !out_valid_reg || rsp_ready;

    // Advance the factoring work
    always_ff @(posedge clk)
    begin
        unique case (cmd.op)
            OP_LOAD:
            begin
                v_reg     <= value;
                d_reg     <= VALUE_BITS'(2);
                sq_reg    <= SQ_BITS'(4);
                hit_reg   <= 1'b0;
                first_reg <= '0;
                rest_reg  <= VALUE_BITS'(1);
            end
            OP_DIV_START:
            begin
                rem_reg  <= '0;
                quo_reg  <= v_reg;
                step_reg <= '0;
            end
            OP_DIV_STEP:
            begin
                rem_reg  <= rem_new;
                quo_reg  <= quo_new;
                step_reg <= step_reg + STEP_BITS'(1);
            end
            OP_REDUCE:
            begin
                // Drop the factor and divide the quotient by it again
                v_reg    <= quo_reg;
                rem_reg  <= '0;
                step_reg <= '0;
                hit_reg  <= 1'b1;
                if (!hit_reg)
                begin
                    if (count_reg == 2'd0)
                    begin
                        first_reg <= d_reg;
                    end
                    else
                    begin
                        rest_reg <= prod[VALUE_BITS-1:0];
                    end
                end
            end
            OP_ADVANCE:
            begin
                hit_reg <= 1'b0;
                if (d_reg == VALUE_BITS'(2))
                begin
                    d_reg  <= VALUE_BITS'(3);
                    sq_reg <= SQ_BITS'(9);
                end
                else
                begin
                    // (d + 2)^2 = d^2 + 4d + 4
                    d_reg  <= d_reg + VALUE_BITS'(2);
                    sq_reg <= sq_reg + {d_reg, 2'b00} + SQ_BITS'(4);
                end
            end
            OP_FINAL:
            begin
                // What remains above one is a prime larger than every trial
                if (v_reg > VALUE_BITS'(1))
                begin
                    if (count_reg == 2'd0)
                    begin
                        first_reg <= v_reg;
                    end
                    else
                    begin
                        rest_reg <= prod[VALUE_BITS-1:0];
                    end
                end
            end
            OP_EMIT:
            begin
                found_reg      <= (count_reg == 2'd2);
                first_out_reg  <= (count_reg == 2'd2) ? first_reg : '0;
                second_out_reg <= (count_reg == 2'd2) ? rest_reg : '0;
            end
            default:
            begin
            end
        endcase
    end

    // Count distinct primes and hold output valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= 2'd0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.op == OP_LOAD)
            begin
                count_reg <= 2'd0;
            end
            else if ((cmd.op == OP_REDUCE && !hit_reg) ||
                     (cmd.op == OP_FINAL && v_reg > VALUE_BITS'(1)))
            begin
                count_reg <= count_inc;
            end

            if (cmd.op == OP_EMIT)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (rsp_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign rsp_valid      = out_valid_reg;
    assign found          = found_reg;
    assign first_divisor  = first_out_reg;
    assign second_divisor = second_out_reg;

endmodule

`default_nettype wire
